// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fdr_pkg.sv =====
package fdr_pkg;

  localparam int SQRT_STEPS = 30;
  localparam int DIV_STEPS  = 17;

  localparam logic signed [15:0] COS_ONE  = 16'sd16384;
  localparam logic [16:0]        REFL_ONE = 17'd65536;
  localparam logic [28:0]        ONE_Q28  = 29'h1000_0000;

  typedef struct packed {
    logic signed [15:0] cos_incident;
    logic [15:0]        index_incident;
    logic [15:0]        index_transmitted;
  } in_t;

  typedef struct packed {
    logic [16:0] reflectance;
    logic        total_internal;
  } out_t;

  // One step of the bit-serial square root, with the operands that ride along.
  typedef struct packed {
    logic [31:0] rem;
    logic [29:0] root;
    logic [59:0] rad;
    logic        tir;
    logic [15:0] ni;
    logic [30:0] nic;
    logic [46:0] nt2c;
  } sq_t;

  // One restoring-division lane.
  typedef struct packed {
    logic [64:0] rem;
    logic [63:0] dsh;
    logic [16:0] q;
    logic        den_zero;
  } dl_t;

  typedef struct packed {
    dl_t  par;
    dl_t  perp;
    logic tir;
  } dv_t;

endpackage

// ===== rtl/fresnel_dielectric_reflectance.sv =====
// Unpolarized Fresnel reflectance of a dielectric boundary. One transaction is
// taken every cycle unless the pipeline is held, and each passes through five front
// stages (clamp and swap, squares, incident sine, Snell products, total
// internal reflection test), a row of 30 square-root cells that produce one
// root bit each, three stages that form the two amplitude ratios, a row of 17
// division cells that produce one quotient bit each for both ratios at once,
// a squaring stage and the output register. The whole row moves together; a
// stalled result holds it only when the squaring stage is also full.
module fresnel_dielectric_reflectance (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fdr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fdr_pkg::out_t out_data
);
  import fdr_pkg::*;

  logic adv;
  logic out_load;

  // Clamp the cosine and swap the indices for a ray that leaves the medium.
  logic signed [15:0] cs_cl;
  logic signed [15:0] cs_neg;
  logic               leaving;
  logic [14:0]        c_in;
  logic [15:0]        ni_in;
  logic [15:0]        nt_in;

  always_comb begin
    cs_cl = in_data.cos_incident;
    if (in_data.cos_incident > COS_ONE) begin
      cs_cl = COS_ONE;
    end else if (in_data.cos_incident < -COS_ONE) begin
      cs_cl = -COS_ONE;
    end
    cs_neg  = -cs_cl;
    leaving = (cs_cl <= 16'sd0);
    c_in    = leaving ? cs_neg[14:0] : cs_cl[14:0];
    ni_in   = leaving ? in_data.index_transmitted : in_data.index_incident;
    nt_in   = leaving ? in_data.index_incident : in_data.index_transmitted;
  end

  logic        s0_v_r, s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic        s8_v_r;
  logic [14:0] c0_r, c1_r;
  logic [15:0] ni0_r, nt0_r, ni1_r, ni2_r, ni3_r;
  logic [28:0] csq1_r, s2_r;
  logic [31:0] nisq1_r, ntsq1_r, nisq2_r, ntsq2_r, ntsq3_r;
  logic [30:0] nic2_r, nic3_r;
  logic [46:0] nt2c2_r, nt2c3_r;
  logic [60:0] lhs3_r;
  sq_t         sq4_r;
  logic [59:0] rhs3;

  logic sq_v [0:SQRT_STEPS];
  sq_t  sq   [0:SQRT_STEPS];

  logic [29:0] u5_r;
  logic [45:0] niu5_r;
  logic [30:0] nic5_r;
  logic [46:0] nt2c5_r;
  logic        tir5_r;

  logic [47:0] ap, bp, ar, br;
  logic [47:0] den_perp6_r, num_perp6_r, den_par6_r, num_par6_r;
  logic        tir6_r;
  dv_t         dv7_r;

  logic dv_v [0:DIV_STEPS];
  dv_t  dv   [0:DIV_STEPS];

  logic [16:0] mag_par, mag_perp;
  logic [33:0] sqpar8_r, sqperp8_r;
  logic        tir8_r;
  logic [34:0] sum8;
  out_t        out_nxt;
  logic        out_valid_r;
  out_t        out_data_r;

  function automatic dl_t lane_init(logic [47:0] num, logic [47:0] den);
    dl_t l;
    l.rem      = {1'b0, num, 16'd0} + {18'd0, den[47:1]};
    l.dsh      = {den, 16'd0};
    l.q        = 17'd0;
    l.den_zero = (den == 48'd0);
    return l;
  endfunction

  assign adv      = !(out_valid_r && out_stall && s8_v_r);
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Valid bits of the stages outside the cell rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= sq_v[SQRT_STEPS];
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  assign rhs3 = {ntsq3_r, 28'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r    <= c_in;
      ni0_r   <= ni_in;
      nt0_r   <= nt_in;

      c1_r    <= c0_r;
      ni1_r   <= ni0_r;
      csq1_r  <= 29'(c0_r) * 29'(c0_r);
      nisq1_r <= 32'(ni0_r) * 32'(ni0_r);
      ntsq1_r <= 32'(nt0_r) * 32'(nt0_r);

      s2_r    <= ONE_Q28 - csq1_r;
      ni2_r   <= ni1_r;
      nisq2_r <= nisq1_r;
      ntsq2_r <= ntsq1_r;
      nic2_r  <= 31'(ni1_r) * 31'(c1_r);
      nt2c2_r <= 47'(ntsq1_r) * 47'(c1_r);

      lhs3_r  <= 61'(nisq2_r) * 61'(s2_r);
      ntsq3_r <= ntsq2_r;
      ni3_r   <= ni2_r;
      nic3_r  <= nic2_r;
      nt2c3_r <= nt2c2_r;

      sq4_r.rem  <= 32'd0;
      sq4_r.root <= 30'd0;
      sq4_r.rad  <= rhs3 - lhs3_r[59:0];
      sq4_r.tir  <= (lhs3_r >= {1'b0, rhs3});
      sq4_r.ni   <= ni3_r;
      sq4_r.nic  <= nic3_r;
      sq4_r.nt2c <= nt2c3_r;
    end
  end

  assign sq_v[0] = s4_v_r;
  assign sq[0]   = sq4_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    fdr_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .in_v  (sq_v[k]),
      .in_c  (sq[k]),
      .out_v (sq_v[k+1]),
      .out_c (sq[k+1])
    );
  end

  always_comb begin
    ap = {17'd0, nic5_r};
    bp = {18'd0, u5_r};
    ar = {1'b0, nt2c5_r};
    br = {2'd0, niu5_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u5_r    <= sq[SQRT_STEPS].root;
      niu5_r  <= 46'(sq[SQRT_STEPS].ni) * 46'(sq[SQRT_STEPS].root);
      nic5_r  <= sq[SQRT_STEPS].nic;
      nt2c5_r <= sq[SQRT_STEPS].nt2c;
      tir5_r  <= sq[SQRT_STEPS].tir;

      den_perp6_r <= ap + bp;
      num_perp6_r <= (ap >= bp) ? (ap - bp) : (bp - ap);
      den_par6_r  <= ar + br;
      num_par6_r  <= (ar >= br) ? (ar - br) : (br - ar);
      tir6_r      <= tir5_r;

      dv7_r.par  <= lane_init(num_par6_r, den_par6_r);
      dv7_r.perp <= lane_init(num_perp6_r, den_perp6_r);
      dv7_r.tir  <= tir6_r;
    end
  end

  assign dv_v[0] = s7_v_r;
  assign dv[0]   = dv7_r;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    fdr_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .in_v  (dv_v[k]),
      .in_c  (dv[k]),
      .out_v (dv_v[k+1]),
      .out_c (dv[k+1])
    );
  end

  // A zero denominator counts as a ratio of one.
  always_comb begin
    mag_par  = dv[DIV_STEPS].par.den_zero ? REFL_ONE : dv[DIV_STEPS].par.q;
    mag_perp = dv[DIV_STEPS].perp.den_zero ? REFL_ONE : dv[DIV_STEPS].perp.q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s8_v_r <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqpar8_r  <= 34'(mag_par) * 34'(mag_par);
      sqperp8_r <= 34'(mag_perp) * 34'(mag_perp);
      tir8_r    <= dv[DIV_STEPS].tir;
    end
  end

  always_comb begin
    sum8 = {1'b0, sqpar8_r} + {1'b0, sqperp8_r} + 35'h1_0000;
    if (tir8_r) begin
      out_nxt.reflectance    = REFL_ONE;
      out_nxt.total_internal = 1'b1;
    end else begin
      out_nxt.reflectance    = sum8[33:17];
      out_nxt.total_internal = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/fdr_sqrt_cell.sv =====
module fdr_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_v,
  input  fdr_pkg::sq_t in_c,
  output logic         out_v,
  output fdr_pkg::sq_t out_c
);
  import fdr_pkg::*;

  logic        v_r;
  sq_t         c_r;
  sq_t         c_nxt;
  logic [33:0] cur;
  logic [33:0] trial;
  logic [33:0] diff;

  always_comb begin
    cur   = {in_c.rem, in_c.rad[59:58]};
    trial = {2'b00, in_c.root, 2'b01};
    diff  = cur - trial;
    c_nxt = in_c;
    c_nxt.rad = {in_c.rad[57:0], 2'b00};
    if (cur >= trial) begin
      c_nxt.rem  = diff[31:0];
      c_nxt.root = {in_c.root[28:0], 1'b1};
    end else begin
      c_nxt.rem  = cur[31:0];
      c_nxt.root = {in_c.root[28:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  assign out_v = v_r;
  assign out_c = c_r;

endmodule

// ===== rtl/fdr_div_cell.sv =====
module fdr_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_v,
  input  fdr_pkg::dv_t in_c,
  output logic         out_v,
  output fdr_pkg::dv_t out_c
);
  import fdr_pkg::*;

  logic v_r;
  dv_t  c_r;
  dv_t  c_nxt;

  // Compare against the divisor at the current bit weight, then halve the divisor.
  function automatic dl_t div_step(dl_t l);
    dl_t  r;
    logic ge;
    r  = l;
    ge = (l.rem >= {1'b0, l.dsh});
    if (ge) begin
      r.rem = l.rem - {1'b0, l.dsh};
    end
    r.q   = {l.q[15:0], ge};
    r.dsh = {1'b0, l.dsh[63:1]};
    return r;
  endfunction

  always_comb begin
    c_nxt      = in_c;
    c_nxt.par  = div_step(in_c.par);
    c_nxt.perp = div_step(in_c.perp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  assign out_v = v_r;
  assign out_c = c_r;

endmodule

// ===== rtl/fdr_checker.sv =====
`include "assert_macros.svh"

module fdr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input fdr_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input fdr_pkg::out_t out_data
);
  import fdr_pkg::*;

  `CHK_ASSERT(a_tir_full, out_valid && out_data.total_internal |-> out_data.reflectance == REFL_ONE, "total internal reflection without full reflectance")
  `CHK_ASSERT(a_refl_range, out_valid |-> out_data.reflectance <= REFL_ONE, "reflectance above one")
  `CHK_ASSERT(a_empty_takes, !out_valid |-> !in_stall, "input stalled while no result is held")
  `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `CHK_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (.*);
